// File: hdl/graphics_control_key_value_parser_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the graphics control key/value parser
// Shared property shapes used by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef GRAPHICS_CONTROL_KEY_VALUE_PARSER_TOP_ASSERT_SVH
`define GRAPHICS_CONTROL_KEY_VALUE_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define KVP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kvp check failed: same-cycle rule");

// Next-cycle implication, disabled during reset.
`define KVP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kvp check failed: next-cycle rule");

`endif

// File: hdl/kvp_pkg.sv
// ----------------------------------------------------------------------------
// kvp_pkg
// Types and constants shared by the key/value parser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kvp_pkg;

   localparam int KEY_COUNT      = 21;
   localparam int CODE_W         = 5;
   localparam int VALUE_W        = 32;
   localparam int FLAG_KEY_COUNT = 4;    // a, t, o, d carry their first byte

   localparam logic [CODE_W-1:0] CODE_Z = 5'd19;  // signed key

   localparam logic [7:0] CHAR_EQ    = 8'h3d;
   localparam logic [7:0] CHAR_COMMA = 8'h2c;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // key bytes in code order: a t o d f m i p q s v x y w h c r X Y z C
   localparam logic [7:0] KEY_TABLE [KEY_COUNT] = '{
      8'h61, 8'h74, 8'h6f, 8'h64, 8'h66, 8'h6d, 8'h69, 8'h70, 8'h71, 8'h73, 8'h76,
      8'h78, 8'h79, 8'h77, 8'h68, 8'h63, 8'h72, 8'h58, 8'h59, 8'h7a, 8'h43
   };

   typedef struct packed {
      logic [7:0] ch;
      logic       char_valid;
      logic       last;
   } req_type;

   typedef struct packed {
      logic               pair_valid;
      logic [CODE_W-1:0]  field_code;
      logic [VALUE_W-1:0] field_value;
      logic               done_res;
      logic               parse_ok;
   } rsp_type;

   typedef struct packed {
      logic              known;
      logic [CODE_W-1:0] code;
   } key_info_type;

endpackage

`default_nettype wire

// File: hdl/graphics_control_key_value_parser_top.sv
// ----------------------------------------------------------------------------
// graphics_control_key_value_parser_top
// Parses a key=value,key=value control string one byte per word and emits
// one (code, value) pair per known key with a non-empty value, plus done/ok on the final word.
// ----------------------------------------------------------------------------
//  channel | ports                           | direction | word
//  --------+---------------------------------+-----------+------------------
//  req     | req_valid, req_stall, req_data  | in        | ch, char_valid, last
//  rsp     | rsp_valid, rsp_stall, rsp_data  | out       | pair, code, value, done, ok
//
//  One word per cycle sustained unless rsp stalls; each word passes through the
//  input register and, if it makes a result, then through the output register.
//  The parse step is combinational (one multiply-by-ten add).
//  Reset is synchronous, active high; it empties both registers and returns
//  the parser to its key phase.
//  A word that makes no result retires even while rsp is stalled; a word
//  that makes a result waits in the input register until the output frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module graphics_control_key_value_parser_top (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire kvp_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output kvp_pkg::rsp_type       rsp_data
);

   // input register
   logic             in_valid_ff, in_valid_in;
   kvp_pkg::req_type in_data_ff;

   // output register
   logic             out_valid_ff, out_valid_in;
   kvp_pkg::rsp_type out_data_ff;

   kvp_pkg::rsp_type step_result;
   logic             step_produces;
   logic             out_free, advance, req_take;

   // output can load when empty or being drained this cycle
   assign out_free  = !out_valid_ff || !rsp_stall;
   // held word retires when it needs no output slot or one is free
   assign advance   = in_valid_ff && (!step_produces || out_free);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   kvp_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .step_en  (advance),
      .item     (in_data_ff),
      .result   (step_result),
      .produces (step_produces)
   );

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_comb begin
      if (advance && step_produces) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (advance && step_produces) begin
         out_data_ff <= step_result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

// File: hdl/kvp_key_decode.sv
// ----------------------------------------------------------------------------
// kvp_key_decode
// Maps a key byte to its field code; flags bytes that are not known keys.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kvp_key_decode (
   input  wire logic [7:0]           key,
   output kvp_pkg::key_info_type     info
);

   always_comb begin
      info = '0;
      for (int k = 0; k < kvp_pkg::KEY_COUNT; k++) begin
         if (!info.known && kvp_pkg::KEY_TABLE[k] == key) begin
            info.known = 1'b1;
            info.code  = kvp_pkg::CODE_W'(k);
         end
      end
   end

endmodule

`default_nettype wire

// File: hdl/kvp_parser.sv
// ----------------------------------------------------------------------------
// kvp_parser
// Parse state and the one-step update for a registered input word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kvp_parser (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step_en,
   input  wire kvp_pkg::req_type  item,
   output kvp_pkg::rsp_type       result,
   output logic                   produces
);

   localparam logic [1:0] PH_KEY  = 2'd0;
   localparam logic [1:0] PH_EQ   = 2'd1;
   localparam logic [1:0] PH_VAL  = 2'd2;
   localparam logic [1:0] PH_FAIL = 2'd3;

   logic [1:0]  phase_ff, phase_in, ph_after;
   logic [7:0]  key_ff, key_in, key_after;
   logic [31:0] acc_ff, acc_in, tv_acc;
   logic [7:0]  first_ff, first_in, tv_first;
   logic        ne_ff, ne_in, tv_ne;
   logic        neg_ff, neg_in, tv_neg;
   logic        nds_ff, nds_in, tv_nds;
   logic        take_byte, take_digit, clear_val, close_req, pair, ok, is_digit;
   logic [31:0] pair_value;
   kvp_pkg::key_info_type key_info;

   kvp_key_decode u_key_decode (
      .key  (key_ff),
      .info (key_info)
   );

   assign is_digit = (item.ch >= kvp_pkg::CHAR_ZERO) && (item.ch <= kvp_pkg::CHAR_NINE);

   always_comb begin
      key_after  = key_ff;
      ph_after   = phase_ff;
      take_byte  = 1'b0;
      clear_val  = 1'b0;
      close_req  = 1'b0;
      if (item.char_valid) begin
         unique case (phase_ff)
            PH_KEY: begin
               key_after = item.ch;
               ph_after  = PH_EQ;
            end
            PH_EQ: begin
               if (item.ch == kvp_pkg::CHAR_EQ) begin
                  clear_val = 1'b1;
                  ph_after  = PH_VAL;
               end else begin
                  ph_after  = PH_FAIL;
               end
            end
            PH_VAL: begin
               if (item.ch == kvp_pkg::CHAR_COMMA) begin
                  close_req = 1'b1;
                  clear_val = 1'b1;
                  ph_after  = PH_KEY;
               end else begin
                  take_byte = 1'b1;
               end
            end
            default: ;
         endcase
      end
      if (item.last && ph_after == PH_VAL) begin
         close_req = 1'b1;
      end
   end

   // value bytes: a leading '-' sets the sign and is not accumulated as a digit
   always_comb begin
      tv_acc     = acc_ff;
      tv_first   = first_ff;
      tv_ne      = ne_ff;
      tv_neg     = neg_ff;
      tv_nds     = nds_ff;
      take_digit = 1'b0;
      if (take_byte) begin
         if (!ne_ff) begin
            tv_first = item.ch;
            if (item.ch == kvp_pkg::CHAR_MINUS) begin
               tv_neg = 1'b1;
               tv_ne  = 1'b1;
            end else begin
               take_digit = 1'b1;
            end
         end else begin
            take_digit = 1'b1;
         end
         if (take_digit) begin
            tv_ne = 1'b1;
            if (is_digit) begin
               tv_acc = {acc_ff[28:0], 3'b000} + {acc_ff[30:0], 1'b0} + {28'd0, item.ch[3:0]};
            end else begin
               tv_nds = 1'b1;
            end
         end
      end
   end

   always_comb begin
      if (key_info.code < kvp_pkg::CODE_W'(kvp_pkg::FLAG_KEY_COUNT)) begin
         pair_value = {24'd0, tv_first};
      end else if (key_info.code == kvp_pkg::CODE_Z) begin
         pair_value = tv_nds ? 32'd0 : (tv_neg ? (32'd0 - tv_acc) : tv_acc);
      end else begin
         pair_value = (tv_nds || tv_neg) ? 32'd0 : tv_acc;
      end
   end

   assign pair     = close_req && tv_ne && key_info.known;
   assign ok       = !(ph_after == PH_EQ || ph_after == PH_FAIL);
   assign produces = pair || item.last;

   always_comb begin
      result.pair_valid  = pair;
      result.field_code  = pair ? key_info.code : '0;
      result.field_value = pair ? pair_value : '0;
      result.done_res    = item.last;
      result.parse_ok    = item.last && ok;
   end

   always_comb begin
      if (item.last) begin
         phase_in = PH_KEY;
         key_in   = '0;
         acc_in   = '0;
         first_in = '0;
         ne_in    = 1'b0;
         neg_in   = 1'b0;
         nds_in   = 1'b0;
      end else begin
         phase_in = ph_after;
         key_in   = key_after;
         acc_in   = clear_val ? '0   : tv_acc;
         first_in = clear_val ? '0   : tv_first;
         ne_in    = clear_val ? 1'b0 : tv_ne;
         neg_in   = clear_val ? 1'b0 : tv_neg;
         nds_in   = clear_val ? 1'b0 : tv_nds;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_KEY;
         key_ff   <= '0;
         acc_ff   <= '0;
         first_ff <= '0;
         ne_ff    <= 1'b0;
         neg_ff   <= 1'b0;
         nds_ff   <= 1'b0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         key_ff   <= key_in;
         acc_ff   <= acc_in;
         first_ff <= first_in;
         ne_ff    <= ne_in;
         neg_ff   <= neg_in;
         nds_ff   <= nds_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/kvp_checker.sv
// ----------------------------------------------------------------------------
// kvp_checker
// Port-level checks on the parser's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "graphics_control_key_value_parser_top_assert.svh"

module kvp_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire kvp_pkg::req_type  req_data,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire kvp_pkg::rsp_type  rsp_data
);

   logic req_seen;
   assign req_seen = req_valid && !req_stall && req_data.last;

   // a result exists only for a finished pair, the end of a string, or while a last word is taken
   `KVP_ASSERT_NOW(a_rsp_reason, clock, reset, rsp_valid, rsp_data.pair_valid || rsp_data.done_res || req_seen)
   // no pair means zeroed code and value
   `KVP_ASSERT_NOW(a_no_pair_zero, clock, reset, rsp_valid && !rsp_data.pair_valid, rsp_data.field_code == '0 && rsp_data.field_value == '0)
   // ok is only reported together with done
   `KVP_ASSERT_NOW(a_ok_with_done, clock, reset, rsp_valid && rsp_data.parse_ok, rsp_data.done_res)
   // a stalled result holds
   `KVP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

endmodule

bind graphics_control_key_value_parser_top kvp_checker u_kvp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
